### design/track_motion_quality_filter_top_defines.svh
// Assertion macros shared by the track motion quality filter modules.
`ifndef TRACK_MOTION_QUALITY_FILTER_TOP_DEFINES_SVH
`define TRACK_MOTION_QUALITY_FILTER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define TMQF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tmqf: same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define TMQF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tmqf: next-cycle check failed");

`endif

### design/tmqf_pkg.sv
// Shared types and constants of the track motion quality filter.
package tmqf_pkg;

  // Fixed field widths
  localparam int unsigned LEN_W     = 25;
  localparam int unsigned WL_W      = 5;
  localparam int unsigned MTD_W     = 29;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned DEV_W     = 16;
  localparam int unsigned DEV_MAG_W = 15;

  // Fixed-point scaling
  localparam int unsigned ACC_FRAC  = 8;
  localparam int unsigned DEV_FRAC  = 14;

  localparam logic [LEN_W-1:0]     LEN_MAX = '1;
  localparam logic [DEV_MAG_W-1:0] DEV_ONE = 15'd16384;

  // Register port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_MIN_TOTAL     = 2'd1,
    REG_ACCEL_BOUND   = 2'd2,
    REG_DEV_BOUND     = 2'd3
  } reg_idx_e;

  // Register reset values
  localparam logic [WL_W-1:0]  WL_RST  = 5'd3;
  localparam logic [MTD_W-1:0] MTD_RST = 29'd2560;
  localparam logic [ACC_W-1:0] ACC_RST = 16'd768;
  localparam logic [DEV_W-1:0] DEV_RST = 16'd0;

  // Control from the sequencer to the length window
  typedef struct packed {
    logic push;       // shift a new length in at the head
    logic sum_start;  // begin a summing pass over the ring
  } win_ctrl_t;

endpackage

### design/tmqf_sermul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`include "track_motion_quality_filter_top_defines.svh"

module tmqf_sermul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               busy_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]   cnt_q;
  logic [A_W-1:0]     a_q;
  logic [B_W-1:0]     b_q;
  logic [A_W+B_W-1:0] acc_q;
  logic [A_W:0]       psum;

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;

  // Add the multiplicand into the upper half when the current bit is set
  assign psum = {1'b0, acc_q[A_W+B_W-1 -: A_W]} + (b_q[0] ? {1'b0, a_q} : '0);

  // Count remaining steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CNT_W'(B_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Shift the partial product right, retire one multiplier bit
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_o) begin
      acc_q <= {psum, acc_q[B_W-1:1]};
      b_q   <= b_q >> 1;
    end
  end

  `TMQF_ASSERT_IMPL(a_mul_load_idle, clk_i, rst_ni, load_i, !busy_o)

endmodule

### design/tmqf_isqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
module tmqf_isqrt #(
  parameter int unsigned ROOT_W = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic                  busy_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0]    cnt_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W+1:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   sub;
  logic [ROOT_W+3:0]   diff;
  logic                fits;

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  // Bring down the next two radicand bits and try the next root bit
  assign trial = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
  assign sub   = {2'b00, root_q, 2'b01};
  assign fits  = (trial >= sub);
  assign diff  = trial - sub;

  // Count remaining root bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CNT_W'(ROOT_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Advance remainder and root by one digit
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? diff[ROOT_W+1:0] : trial[ROOT_W+1:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

endmodule

### design/tmqf_window.sv
// Ring of recent step lengths with a serial summing pass.
`include "track_motion_quality_filter_top_defines.svh"

module tmqf_window #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tmqf_pkg::win_ctrl_t                   ctrl_i,
  input  logic [tmqf_pkg::LEN_W-1:0]            len_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]       n_i,
  output logic                                  busy_o,
  output logic [tmqf_pkg::LEN_W-1:0]            prev_o,
  output logic [tmqf_pkg::LEN_W+$clog2(WINDOW_MAX+1)-1:0] sum_o
);

  localparam int unsigned LEN_W = tmqf_pkg::LEN_W;
  localparam int unsigned WN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IX_W  = $clog2(WINDOW_MAX);
  localparam int unsigned SUM_W = LEN_W + WN_W;

  logic [LEN_W-1:0] ring_q [WINDOW_MAX];
  logic [IX_W-1:0]  idx_q;
  logic             busy_q;
  logic [SUM_W-1:0] sum_q;

  assign busy_o = busy_q;
  assign prev_o = ring_q[0];
  assign sum_o  = sum_q;

  // Step through the ring once per summing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (ctrl_i.sum_start) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      idx_q <= idx_q + 1'b1;
      if (idx_q == IX_W'(WINDOW_MAX - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Push at the head, or rotate toward the head while summing
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ring_q[0] <= len_i;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        ring_q[i] <= ring_q[i-1];
      end
    end else if (busy_q) begin
      ring_q[WINDOW_MAX-1] <= ring_q[0];
      for (int i = 0; i < WINDOW_MAX - 1; i++) begin
        ring_q[i] <= ring_q[i+1];
      end
    end
  end

  // Accumulate the newest n lengths as they pass the head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_start) begin
      sum_q <= '0;
    end else if (busy_q && (WN_W'(idx_q) < n_i)) begin
      sum_q <= sum_q + SUM_W'(ring_q[0]);
    end
  end

  `TMQF_ASSERT_IMPL(a_win_start_idle, clk_i, rst_ni, ctrl_i.sum_start, !busy_q)
  `TMQF_ASSERT_IMPL(a_win_push_idle, clk_i, rst_ni, ctrl_i.push, !busy_q)

endmodule

### design/track_motion_quality_filter_top.sv
// Top level of the track motion quality filter: registers, sequencer and tests.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_ready_o  start_track_i, pos_x_i, pos_y_i
//  out       source     out_valid_o/out_ready_i step_length_o, displacement_small_o,
//                                               motion_smooth_o
//  config    APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// One item at a time. An item that continues a track passes through serial
// multipliers over COORD_BITS+1 bits, a square root at two bits per cycle, then
// the window ring pass and the 25-bit serial product. A track start skips these.
// Reset is asynchronous and clears control, history and registers; the window
// ring itself is not cleared. A finished result waits in the output register
// while the next item is accepted; the sequencer holds only if that is still full.
`include "track_motion_quality_filter_top_defines.svh"

module track_motion_quality_filter_top #(
  parameter int unsigned WINDOW_MAX = 16,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmqf_pkg::APB_AW-1:0]         paddr,
  input  logic [tmqf_pkg::APB_DW-1:0]         pwdata,
  output logic [tmqf_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // Point input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                start_track_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tmqf_pkg::LEN_W-1:0]          step_length_o,
  output logic                                displacement_small_o,
  output logic                                motion_smooth_o
);

  localparam int unsigned LEN_W     = tmqf_pkg::LEN_W;
  localparam int unsigned WL_W      = tmqf_pkg::WL_W;
  localparam int unsigned MTD_W     = tmqf_pkg::MTD_W;
  localparam int unsigned ACC_W     = tmqf_pkg::ACC_W;
  localparam int unsigned DEV_W     = tmqf_pkg::DEV_W;
  localparam int unsigned DEV_MAG_W = tmqf_pkg::DEV_MAG_W;
  localparam int unsigned APB_AW    = tmqf_pkg::APB_AW;
  localparam int unsigned APB_DW    = tmqf_pkg::APB_DW;

  localparam int unsigned MAG_W = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * MAG_W;
  localparam int unsigned PC_W  = $clog2(WINDOW_MAX + 2);
  localparam int unsigned WN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CNT_W = (PC_W > WL_W) ? PC_W : WL_W;
  localparam int unsigned SUM_W = LEN_W + WN_W;
  localparam int unsigned THR_W = (SUM_W > MTD_W) ? SUM_W : MTD_W;
  localparam int unsigned RT_W  = (MAG_W > LEN_W) ? MAG_W : LEN_W;
  localparam int unsigned DL_W  = LEN_W + DEV_MAG_W;
  localparam int unsigned RHS_W = DL_W + LEN_W;
  localparam int unsigned LHS_W = SQ_W + tmqf_pkg::DEV_FRAC;
  localparam int unsigned CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int unsigned RAT_W = LEN_W + ACC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ROOT,
    ST_TEST,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------- registers
  logic [WL_W-1:0]   wl_q;
  logic [MTD_W-1:0]  mtd_q;
  logic [ACC_W-1:0]  acc_q;
  logic [DEV_W-1:0]  dev_q;
  logic              cfg_wr;
  tmqf_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tmqf_pkg::reg_idx_e'(paddr[APB_AW-1:2]);

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q  <= tmqf_pkg::WL_RST;
      mtd_q <= tmqf_pkg::MTD_RST;
      acc_q <= tmqf_pkg::ACC_RST;
      dev_q <= tmqf_pkg::DEV_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmqf_pkg::REG_WINDOW_LENGTH: wl_q  <= pwdata[WL_W-1:0];
        tmqf_pkg::REG_MIN_TOTAL:     mtd_q <= pwdata[MTD_W-1:0];
        tmqf_pkg::REG_ACCEL_BOUND:   acc_q <= pwdata[ACC_W-1:0];
        tmqf_pkg::REG_DEV_BOUND:     dev_q <= pwdata[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      tmqf_pkg::REG_WINDOW_LENGTH: prdata = APB_DW'(wl_q);
      tmqf_pkg::REG_MIN_TOTAL:     prdata = APB_DW'(mtd_q);
      tmqf_pkg::REG_ACCEL_BOUND:   prdata = APB_DW'(acc_q);
      tmqf_pkg::REG_DEV_BOUND:     prdata = APB_DW'(dev_q);
      default:                     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ declarations
  state_e               state_q;
  logic                 start_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [COORD_BITS-1:0] last_x_q, last_y_q;
  logic [MAG_W-1:0]     last_dx_q, last_dy_q;
  logic [PC_W-1:0]      pc_q;

  logic [PC_W-1:0]      pc_eff, pc_new;
  logic [CNT_W-1:0]     n_eff, lengths;
  logic                 first;
  logic [MAG_W-1:0]     dx, dy, mx, my, ax, ay;
  logic [DEV_W-1:0]     dev_neg_val;
  logic [DEV_W-1:0]     dev_mag16;
  logic [DEV_MAG_W-1:0] dev_mag;

  logic                 smooth_test_q, have_n_q;
  logic                 n1_q, n2_q, devneg_q;
  logic [LEN_W-1:0]     l1_q, hi_q;
  logic                 dn_q;
  logic [SQ_W-1:0]      dm_q;

  logic [LEN_W-1:0]     res_len_q;
  logic                 res_small_q, res_smooth_q;
  logic                 out_valid_q;
  logic [LEN_W-1:0]     out_len_q;
  logic                 out_small_q, out_smooth_q;

  logic                 mul_load, mul_busy, mul_exit;
  logic                 root_busy, root_exit;
  logic                 test_busy;
  logic                 done_go;

  logic [SQ_W-1:0]      mxx_prod, myy_prod, pxx_prod, pyy_prod;
  logic                 mxx_busy, myy_busy, pxx_busy, pyy_busy, dl1_busy;
  logic [DL_W-1:0]      dl1_prod;
  logic                 dl2_busy, rat_busy;
  logic [RHS_W-1:0]     dl2_prod;
  logic [RAT_W-1:0]     rat_prod;

  logic [SQ_W:0]        sq_full, dot_sum, dot_d12, dot_d21;
  logic                 dn_d;
  logic [SQ_W-1:0]      dm_d;
  logic [MAG_W-1:0]     root;
  logic [LEN_W-1:0]     len, lo, hi;

  tmqf_pkg::win_ctrl_t  win_ctrl;
  logic                 win_busy;
  logic [LEN_W-1:0]     win_prev;
  logic [SUM_W-1:0]     win_sum;

  logic [CMP_W-1:0]     lhs, rhs;
  logic                 an, bn, cos_ok, ratio_ok, smooth_d, small_d;

  // ------------------------------------------------------ displacement step
  assign pc_eff  = start_q ? '0 : pc_q;
  assign first   = (pc_eff == '0);
  assign pc_new  = (pc_eff < PC_W'(WINDOW_MAX + 1)) ? pc_eff + 1'b1 : pc_eff;
  assign lengths = CNT_W'(pc_new) - 1'b1;

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (wl_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(wl_q) > CNT_W'(WINDOW_MAX)) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = CNT_W'(wl_q);
    end
  end

  assign dx = {x_q[COORD_BITS-1], x_q} - {last_x_q[COORD_BITS-1], last_x_q};
  assign dy = {y_q[COORD_BITS-1], y_q} - {last_y_q[COORD_BITS-1], last_y_q};
  assign mx = dx[MAG_W-1] ? (~dx + 1'b1) : dx;
  assign my = dy[MAG_W-1] ? (~dy + 1'b1) : dy;
  assign ax = last_dx_q[MAG_W-1] ? (~last_dx_q + 1'b1) : last_dx_q;
  assign ay = last_dy_q[MAG_W-1] ? (~last_dy_q + 1'b1) : last_dy_q;

  // Clamp the cosine bound to plus or minus one
  assign dev_neg_val = ~dev_q + 1'b1;
  assign dev_mag16   = dev_q[DEV_W-1] ? dev_neg_val : dev_q;
  assign dev_mag     = (dev_mag16 > DEV_W'(tmqf_pkg::DEV_ONE)) ?
                       tmqf_pkg::DEV_ONE : dev_mag16[DEV_MAG_W-1:0];

  // ------------------------------------------------------ phase handshakes
  assign mul_load  = (state_q == ST_DIFF) && !first;
  assign mul_busy  = mxx_busy || myy_busy || pxx_busy || pyy_busy || dl1_busy;
  assign mul_exit  = (state_q == ST_MUL) && !mul_busy;
  assign root_exit = (state_q == ST_ROOT) && !root_busy;
  assign test_busy = dl2_busy || rat_busy || win_busy;
  assign done_go   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign in_ready_o           = (state_q == ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign step_length_o        = out_len_q;
  assign displacement_small_o = out_small_q;
  assign motion_smooth_o      = out_smooth_q;

  // ------------------------------------------------------ serial products
  tmqf_sermul #(.A_W(MAG_W), .B_W(MAG_W)) u_mxx (
    .clk_i, .rst_ni, .load_i(mul_load), .a_i(mx), .b_i(mx),
    .busy_o(mxx_busy), .prod_o(mxx_prod)
  );

  tmqf_sermul #(.A_W(MAG_W), .B_W(MAG_W)) u_myy (
    .clk_i, .rst_ni, .load_i(mul_load), .a_i(my), .b_i(my),
    .busy_o(myy_busy), .prod_o(myy_prod)
  );

  tmqf_sermul #(.A_W(MAG_W), .B_W(MAG_W)) u_pxx (
    .clk_i, .rst_ni, .load_i(mul_load), .a_i(ax), .b_i(mx),
    .busy_o(pxx_busy), .prod_o(pxx_prod)
  );

  tmqf_sermul #(.A_W(MAG_W), .B_W(MAG_W)) u_pyy (
    .clk_i, .rst_ni, .load_i(mul_load), .a_i(ay), .b_i(my),
    .busy_o(pyy_busy), .prod_o(pyy_prod)
  );

  tmqf_sermul #(.A_W(LEN_W), .B_W(DEV_MAG_W)) u_dl1 (
    .clk_i, .rst_ni, .load_i(mul_load), .a_i(win_prev), .b_i(dev_mag),
    .busy_o(dl1_busy), .prod_o(dl1_prod)
  );

  // Radicand and signed dot product from the finished products
  assign sq_full = {1'b0, mxx_prod} + {1'b0, myy_prod};
  assign dot_sum = {1'b0, pxx_prod} + {1'b0, pyy_prod};
  assign dot_d12 = {1'b0, pxx_prod} - {1'b0, pyy_prod};
  assign dot_d21 = {1'b0, pyy_prod} - {1'b0, pxx_prod};

  always_comb begin
    if (n1_q == n2_q) begin
      dn_d = n1_q;
      dm_d = dot_sum[SQ_W-1:0];
    end else if (pxx_prod >= pyy_prod) begin
      dn_d = n1_q;
      dm_d = dot_d12[SQ_W-1:0];
    end else begin
      dn_d = n2_q;
      dm_d = dot_d21[SQ_W-1:0];
    end
  end

  tmqf_isqrt #(.ROOT_W(MAG_W)) u_root (
    .clk_i, .rst_ni, .load_i(mul_exit), .radicand_i(sq_full[SQ_W-1:0]),
    .busy_o(root_busy), .root_o(root)
  );

  // Saturate the root to the length field
  assign len = (RT_W'(root) > RT_W'(tmqf_pkg::LEN_MAX)) ? tmqf_pkg::LEN_MAX : LEN_W'(root);
  assign lo  = (l1_q > len) ? len : l1_q;
  assign hi  = (l1_q > len) ? l1_q : len;

  assign win_ctrl.push      = root_exit;
  assign win_ctrl.sum_start = root_exit;

  tmqf_window #(.WINDOW_MAX(WINDOW_MAX)) u_window (
    .clk_i, .rst_ni, .ctrl_i(win_ctrl), .len_i(len), .n_i(WN_W'(n_eff)),
    .busy_o(win_busy), .prev_o(win_prev), .sum_o(win_sum)
  );

  tmqf_sermul #(.A_W(DL_W), .B_W(LEN_W)) u_dl2 (
    .clk_i, .rst_ni, .load_i(root_exit), .a_i(dl1_prod), .b_i(len),
    .busy_o(dl2_busy), .prod_o(dl2_prod)
  );

  tmqf_sermul #(.A_W(LEN_W), .B_W(ACC_W)) u_rat (
    .clk_i, .rst_ni, .load_i(root_exit), .a_i(lo), .b_i(acc_q),
    .busy_o(rat_busy), .prod_o(rat_prod)
  );

  // ------------------------------------------------------ final tests
  assign lhs = CMP_W'(dm_q) << tmqf_pkg::DEV_FRAC;
  assign rhs = CMP_W'(dl2_prod);
  assign an  = dn_q && (dm_q != '0);
  assign bn  = devneg_q && (rhs != '0);
  assign cos_ok   = (an != bn) ? bn : (an ? (lhs < rhs) : (lhs > rhs));
  assign ratio_ok = ((RAT_W'(hi_q) << tmqf_pkg::ACC_FRAC) < rat_prod);
  assign smooth_d = !smooth_test_q ||
                    ((l1_q != '0) && (res_len_q != '0) && ratio_ok && cos_ok);
  assign small_d  = have_n_q && (THR_W'(win_sum) <= THR_W'(mtd_q));

  // Capture the accepted point
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q <= start_track_i;
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
    end
  end

  // Hold per-item test operands
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIFF) begin
      smooth_test_q <= (pc_eff >= PC_W'(2));
      have_n_q      <= (lengths >= n_eff);
      n1_q          <= last_dx_q[MAG_W-1] ^ dx[MAG_W-1];
      n2_q          <= last_dy_q[MAG_W-1] ^ dy[MAG_W-1];
      devneg_q      <= dev_q[DEV_W-1];
      l1_q          <= win_prev;
    end
    if (mul_exit) begin
      dn_q <= dn_d;
      dm_q <= dm_d;
    end
    if (root_exit) begin
      hi_q <= hi;
    end
  end

  // Sequence the item, keep track history, hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_dx_q    <= '0;
      last_dy_q    <= '0;
      pc_q         <= '0;
      res_len_q    <= '0;
      res_small_q  <= 1'b0;
      res_smooth_q <= 1'b1;
      out_valid_q  <= 1'b0;
      out_len_q    <= '0;
      out_small_q  <= 1'b0;
      out_smooth_q <= 1'b0;
    end else begin
      // Drop the shown item once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && !done_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          last_x_q <= x_q;
          last_y_q <= y_q;
          pc_q     <= pc_new;
          if (first) begin
            last_dx_q    <= '0;
            last_dy_q    <= '0;
            res_len_q    <= '0;
            res_small_q  <= 1'b0;
            res_smooth_q <= 1'b1;
            state_q      <= ST_DONE;
          end else begin
            last_dx_q <= dx;
            last_dy_q <= dy;
            state_q   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!mul_busy) begin
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (!root_busy) begin
            res_len_q <= len;
            state_q   <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (!test_busy) begin
            res_small_q  <= small_d;
            res_smooth_q <= smooth_d;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            out_valid_q  <= 1'b1;
            out_len_q    <= res_len_q;
            out_small_q  <= res_small_q;
            out_smooth_q <= res_smooth_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `TMQF_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TMQF_ASSERT_NEXT(a_done_shows, clk_i, rst_ni, done_go, out_valid_q)
  `TMQF_ASSERT_IMPL(a_root_before_test, clk_i, rst_ni, state_q == ST_TEST, !root_busy)

endmodule
